/* rtl/bbr_pkg.sv */
// Shared constants, types and the reciprocal table of the box blur row filter.
package bbr_pkg;

	localparam int MAX_RADIUS    = 31;
	localparam int MAX_WIDTH_DEF = 4096;

	localparam int PIX_W      = 32;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 24;
	localparam int RADIUS_W   = 5;
	localparam int ROW_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	// window store: 2*MAX_RADIUS+2 entries, addressed by the column's low bits
	localparam int ADDR_W = 6;

	localparam int SUM_W       = 14;
	localparam int MUL_W       = RADIUS_W + 1;
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd1;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 5'd1;
	localparam logic [ROW_W-1:0]    ROW_RST    = 13'd4096;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_INIT   = 2'd0;
	localparam kind_t KIND_ADD    = 2'd1;
	localparam kind_t KIND_SUBADD = 2'd2;

	typedef struct packed {
		logic go1;
		logic ld2;
		logic ld3;
	} lane_ctl_t;

	// ceil(2^20 / (2r+1)); exact floor quotient for sums below 2^14
	function automatic logic [RECIP_W-1:0] recip(input logic [RADIUS_W-1:0] r);
		logic [RECIP_W-1:0] m;
		case (r)
			5'd0:    m = 21'd1048576;
			5'd1:    m = 21'd349526;
			5'd2:    m = 21'd209716;
			5'd3:    m = 21'd149797;
			5'd4:    m = 21'd116509;
			5'd5:    m = 21'd95326;
			5'd6:    m = 21'd80660;
			5'd7:    m = 21'd69906;
			5'd8:    m = 21'd61681;
			5'd9:    m = 21'd55189;
			5'd10:   m = 21'd49933;
			5'd11:   m = 21'd45591;
			5'd12:   m = 21'd41944;
			5'd13:   m = 21'd38837;
			5'd14:   m = 21'd36158;
			5'd15:   m = 21'd33826;
			5'd16:   m = 21'd31776;
			5'd17:   m = 21'd29960;
			5'd18:   m = 21'd28340;
			5'd19:   m = 21'd26887;
			5'd20:   m = 21'd25576;
			5'd21:   m = 21'd24386;
			5'd22:   m = 21'd23302;
			5'd23:   m = 21'd22311;
			5'd24:   m = 21'd21400;
			5'd25:   m = 21'd20561;
			5'd26:   m = 21'd19785;
			5'd27:   m = 21'd19066;
			5'd28:   m = 21'd18397;
			5'd29:   m = 21'd17773;
			5'd30:   m = 21'd17190;
			5'd31:   m = 21'd16645;
			default: m = 21'd1048576;
		endcase
		return m;
	endfunction

endpackage

/* rtl/box_blur_row_filter.sv */
// Horizontal box blur over a pixel stream, running sum per color channel.
//
//  channel   direction  payload                                       handshake
//  s_axis    in         tdata: pixel_in[31:0]                         tvalid/tready
//  m_axis    out        tdata: pixel_out[31:0], tlast: row_last       tvalid/tready
//  cfg       in         index 0 radius[4:0], index 1 row_width[12:0]  valid/ready
//
// Cycles: one pixel per clock inside a row while the output is not stalled. The
// item that closes a row holds the input while radius flushed columns of the
// right edge go through, one result per unstalled cycle; the single running-sum
// update per channel sets that pace. Registered stages: issue, sum, multiply, out.
// Reset: asynchronous, active low; radius 1, row width 4096, column zero.
// Stalls: each stage holds while its successor is full; bubbles are squeezed out.
// A register write restarts the row at column 0.
module box_blur_row_filter #(
	parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [bbr_pkg::PIX_W-1:0]          s_axis_tdata,  // pixel_in[31:0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [bbr_pkg::PIX_W-1:0]          m_axis_tdata,  // pixel_out[31:0]
	output logic                               m_axis_tlast,  // row_last
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bbr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// column of the next input; flush column runs past the row end by radius
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int TW = $clog2(MAX_WIDTH + 64);

	localparam int AW = bbr_pkg::ADDR_W;
	localparam int CH = bbr_pkg::CHAN_W;

	// config
	logic [bbr_pkg::RADIUS_W-1:0] radius_q;
	logic [bbr_pkg::ROW_W-1:0]    row_width_q;
	logic                         cfg_wr;

	// issue state
	logic [CW-1:0]                in_col_q;
	logic                         fl_q;
	logic [TW-1:0]                fl_t_q;
	logic [bbr_pkg::COLOR_W-1:0]  fl_pix_q;
	logic [bbr_pkg::COLOR_W-1:0]  first_pix_q;

	// issue logic
	logic [bbr_pkg::RADIUS_W-1:0] r_eff;
	logic [TW-1:0]                w_eff;
	logic [TW-1:0]                rr;
	logic [TW-1:0]                two_r1;
	logic [CW-1:0]                col_c;
	logic [TW-1:0]                t;
	logic [TW-1:0]                j;
	logic [TW-1:0]                t_sub;
	logic [bbr_pkg::COLOR_W-1:0]  p_col;
	logic                         fire;
	logic                         accept;
	logic                         row_end;
	logic                         emit;
	logic                         sub_first;
	bbr_pkg::kind_t               kind;

	// pipeline
	logic                         v_s1, v_s2, v_s3;
	bbr_pkg::kind_t               kind_s1;
	logic                         emit_s1;
	logic                         last_s1, last_s2, last_s3;
	logic                         subf_s1;
	logic                         abyp_s1;
	logic [CH-1:0]                abyp_val_s1;
	logic [bbr_pkg::COLOR_W-1:0]  pix_s1;
	logic [CH-1:0]                alpha_s2, alpha_s3;
	logic                         ov_q;
	logic [bbr_pkg::PIX_W-1:0]    odata_q;
	logic                         olast_q;

	logic                         rdy_o, rdy3, rdy2, rdy1, go1;
	bbr_pkg::lane_ctl_t           lctl;

	logic [bbr_pkg::PIX_W-1:0]    rd_sub;
	logic [bbr_pkg::PIX_W-1:0]    rd_alpha;
	logic [bbr_pkg::COLOR_W-1:0]  sub_pix;
	logic [bbr_pkg::RECIP_W-1:0]  recip;
	logic [bbr_pkg::MUL_W-1:0]    mul;
	logic [CH-1:0]                q_r, q_g, q_b;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// effective geometry
	always_comb begin
		r_eff = (radius_q > bbr_pkg::RADIUS_W'(bbr_pkg::MAX_RADIUS)) ?
			bbr_pkg::RADIUS_W'(bbr_pkg::MAX_RADIUS) : radius_q;
		if (row_width_q == '0) begin
			w_eff = TW'(1);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = TW'(MAX_WIDTH);
		end else begin
			w_eff = TW'(row_width_q);
		end
	end

	assign rr     = TW'(r_eff);
	assign two_r1 = (rr << 1) + TW'(1);
	assign recip  = bbr_pkg::recip(r_eff);
	assign mul    = bbr_pkg::MUL_W'(r_eff) + bbr_pkg::MUL_W'(1);

	// handshake chain, output register back to issue
	assign rdy_o = !ov_q || m_axis_tready;
	assign rdy3  = !v_s3 || rdy_o;
	assign rdy2  = !v_s2 || rdy3;
	assign go1   = v_s1 && (!emit_s1 || rdy2);
	assign rdy1  = !v_s1 || go1;

	assign lctl.go1 = go1;
	assign lctl.ld2 = rdy2;
	assign lctl.ld3 = rdy3;

	assign s_axis_tready = rdy1 && !fl_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fire          = rdy1 && (fl_q || s_axis_tvalid);

	// right-edge column of this step: a real input or a flushed copy of the last
	always_comb begin
		col_c   = (TW'(in_col_q) >= w_eff) ? '0 : in_col_q;
		t       = fl_q ? fl_t_q : TW'(col_c);
		p_col   = fl_q ? fl_pix_q : s_axis_tdata[bbr_pkg::COLOR_W-1:0];
		row_end = !fl_q && (TW'(col_c) == w_eff - TW'(1));
		if (t == '0) begin
			kind = bbr_pkg::KIND_INIT;
		end else if (t <= rr) begin
			kind = bbr_pkg::KIND_ADD;
		end else begin
			kind = bbr_pkg::KIND_SUBADD;
		end
		// columns left of the row read back as the first pixel
		sub_first = (t <= two_r1);
		emit      = (t >= rr);
		j         = t - rr;
		// column leaving the window
		t_sub     = t - two_r1;
	end

	bbr_window u_window (
		.clk     (clk),
		.we      (accept),
		.waddr   (t[AW-1:0]),
		.wdata   (s_axis_tdata),
		.re      (fire),
		.raddr_a (t_sub[AW-1:0]),
		.raddr_b (j[AW-1:0]),
		.rdata_a (rd_sub),
		.rdata_b (rd_alpha)
	);

	// config and issue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= bbr_pkg::RADIUS_RST;
			row_width_q <= bbr_pkg::ROW_RST;
			in_col_q    <= '0;
			fl_q        <= 1'b0;
			fl_t_q      <= '0;
			fl_pix_q    <= '0;
			first_pix_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				bbr_pkg::REG_RADIUS: begin
					radius_q <= cfg_data[bbr_pkg::RADIUS_W-1:0];
					in_col_q <= '0;
					fl_q     <= 1'b0;
				end
				bbr_pkg::REG_ROW_WIDTH: begin
					row_width_q <= cfg_data[bbr_pkg::ROW_W-1:0];
					in_col_q    <= '0;
					fl_q        <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (fire) begin
			if (fl_q) begin
				if (fl_t_q == w_eff + rr - TW'(1)) begin
					fl_q <= 1'b0;
				end
				fl_t_q <= fl_t_q + TW'(1);
			end else begin
				if (col_c == '0) begin
					first_pix_q <= p_col;
				end
				if (row_end) begin
					in_col_q <= '0;
					fl_q     <= (r_eff != '0);
					fl_t_q   <= w_eff;
					fl_pix_q <= p_col;
				end else begin
					in_col_q <= col_c + CW'(1);
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= fire;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && emit_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_o) begin
				ov_q <= v_s3;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1     <= kind;
			emit_s1     <= emit;
			last_s1     <= (j == w_eff - TW'(1));
			subf_s1     <= sub_first;
			pix_s1      <= p_col;
			// zero radius: the alpha source is the pixel being written now
			abyp_s1     <= (r_eff == '0);
			abyp_val_s1 <= s_axis_tdata[bbr_pkg::PIX_W-1 -: CH];
		end
		if (rdy2) begin
			last_s2  <= last_s1;
			alpha_s2 <= abyp_s1 ? abyp_val_s1 : rd_alpha[bbr_pkg::PIX_W-1 -: CH];
		end
		if (rdy3) begin
			last_s3  <= last_s2;
			alpha_s3 <= alpha_s2;
		end
		if (rdy_o) begin
			odata_q <= {alpha_s3, q_r, q_g, q_b};
			olast_q <= last_s3;
		end
	end

	assign sub_pix = subf_s1 ? first_pix_q : rd_sub[bbr_pkg::COLOR_W-1:0];

	bbr_lane u_lane_r (
		.clk     (clk),
		.ctl     (lctl),
		.kind    (kind_s1),
		.add_val (pix_s1[2*CH +: CH]),
		.sub_val (sub_pix[2*CH +: CH]),
		.mul     (mul),
		.recip   (recip),
		.quo     (q_r)
	);

	bbr_lane u_lane_g (
		.clk     (clk),
		.ctl     (lctl),
		.kind    (kind_s1),
		.add_val (pix_s1[CH +: CH]),
		.sub_val (sub_pix[CH +: CH]),
		.mul     (mul),
		.recip   (recip),
		.quo     (q_g)
	);

	bbr_lane u_lane_b (
		.clk     (clk),
		.ctl     (lctl),
		.kind    (kind_s1),
		.add_val (pix_s1[0 +: CH]),
		.sub_val (sub_pix[0 +: CH]),
		.mul     (mul),
		.recip   (recip),
		.quo     (q_b)
	);

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tlast  = olast_q;

endmodule

/* rtl/bbr_window.sv */
// Window store: recent pixels of the row, one write and two registered reads.
module bbr_window (
	input  logic                           clk,
	input  logic                           we,
	input  logic [bbr_pkg::ADDR_W-1:0]     waddr,
	input  logic [bbr_pkg::PIX_W-1:0]      wdata,
	input  logic                           re,
	input  logic [bbr_pkg::ADDR_W-1:0]     raddr_a,
	input  logic [bbr_pkg::ADDR_W-1:0]     raddr_b,
	output logic [bbr_pkg::PIX_W-1:0]      rdata_a,
	output logic [bbr_pkg::PIX_W-1:0]      rdata_b
);

	localparam int DEPTH = 1 << bbr_pkg::ADDR_W;

	logic [bbr_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// only read port b at zero radius hits the address written in the same cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* rtl/bbr_lane.sv */
// One color channel: running window sum and reciprocal-multiply mean.
module bbr_lane (
	input  logic                              clk,
	input  bbr_pkg::lane_ctl_t                ctl,
	input  bbr_pkg::kind_t                    kind,
	input  logic [bbr_pkg::CHAN_W-1:0]        add_val,
	input  logic [bbr_pkg::CHAN_W-1:0]        sub_val,
	input  logic [bbr_pkg::MUL_W-1:0]         mul,
	input  logic [bbr_pkg::RECIP_W-1:0]       recip,
	output logic [bbr_pkg::CHAN_W-1:0]        quo
);

	logic [bbr_pkg::SUM_W-1:0]  sum_q;
	logic [bbr_pkg::SUM_W-1:0]  sum_nxt;
	logic [bbr_pkg::SUM_W-1:0]  sum_s2;
	logic [bbr_pkg::PROD_W-1:0] prod;
	logic [bbr_pkg::PROD_W-1:0] prod_s3;

	always_comb begin
		case (kind)
			bbr_pkg::KIND_INIT: begin
				// row start: left edge replicates the first pixel r+1 times
				sum_nxt = bbr_pkg::SUM_W'(add_val) * bbr_pkg::SUM_W'(mul);
			end
			bbr_pkg::KIND_ADD: begin
				sum_nxt = sum_q + bbr_pkg::SUM_W'(add_val);
			end
			bbr_pkg::KIND_SUBADD: begin
				sum_nxt = sum_q - bbr_pkg::SUM_W'(sub_val) + bbr_pkg::SUM_W'(add_val);
			end
			default: begin
				sum_nxt = sum_q;
			end
		endcase
	end

	assign prod = bbr_pkg::PROD_W'(sum_s2) * bbr_pkg::PROD_W'(recip);
	assign quo  = prod_s3[bbr_pkg::RECIP_SHIFT +: bbr_pkg::CHAN_W];

	always_ff @(posedge clk) begin
		if (ctl.go1) begin
			sum_q <= sum_nxt;
		end
		if (ctl.ld2) begin
			sum_s2 <= sum_nxt;
		end
		if (ctl.ld3) begin
			prod_s3 <= prod;
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for box_blur_row_filter: directed table, then random rows.
module testbench;
	import bbr_pkg::*;

	// window store depth, mirrors the block's circular pixel store
	localparam int STORE_DEPTH  = 2 * MAX_RADIUS + 2;
	// cycles let pass after the last expected item before a register write
	localparam int SETTLE       = 8;
	localparam int END_DRAIN    = 20;
	// cycles with no handshake on any channel before the run is declared hung
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 300;
	localparam int ROW_REG_MAX  = (1 << ROW_W) - 1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} blurred_t;

	typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

	// one line of the directed table: a pixel item or a register write
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [PIX_W-1:0]      value;
		logic                  typed;   // want holds the single result of this item
		blurred_t              want;
	} stim_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata  = '0;   // pixel_in[31:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIX_W-1:0]      m_axis_tdata;         // pixel_out[31:0]
	logic                  m_axis_tlast;         // row_last
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	box_blur_row_filter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Blur predictor: own copy of registers, window and running sums
	// ---------------------------------------------------------------
	logic [RADIUS_W-1:0] radius_q  = RADIUS_RST;
	logic [ROW_W-1:0]    width_q   = ROW_RST;
	logic [PIX_W-1:0]    win_px [STORE_DEPTH];
	logic [COLOR_W-1:0]  first_rgb = '0;
	int                  sum_r     = 0;
	int                  sum_g     = 0;
	int                  sum_b     = 0;
	int                  in_col    = 0;
	int                  out_col   = 0;

	blurred_t blur_q [$];   // blurred pixels still owed by the block, oldest first

	int errors      = 0;
	bit steady      = 1'b0; // no gaps on either side while set
	int stall_left  = 0;
	int idle_cycles = 0;

	// zero width acts as one pixel, oversized widths clamp to the maximum
	function automatic int row_len();
		if (width_q == 0)
			return 1;
		if (width_q > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return int'(width_q);
	endfunction

	function automatic void sums_add_px(logic [PIX_W-1:0] p, int times);
		sum_r += int'(p[23:16]) * times;
		sum_g += int'(p[15:8]) * times;
		sum_b += int'(p[7:0]) * times;
	endfunction

	function automatic void sums_drop_px(logic [PIX_W-1:0] p);
		sum_r -= int'(p[23:16]);
		sum_g -= int'(p[15:8]);
		sum_b -= int'(p[7:0]);
	endfunction

	// truncated mean of the window; alpha from the pixel at the same column
	function automatic void emit_blurred(int r, int w);
		int       div;
		int       j;
		blurred_t res;
		div = 2 * r + 1;
		j = out_col;
		res.pixel = {win_px[j % STORE_DEPTH][31:24], 8'(sum_r / div),
			8'(sum_g / div), 8'(sum_b / div)};
		res.last = (j == w - 1);
		blur_q.push_back(res);
		out_col = j + 1;
	endfunction

	// right window edge reaches column t with pixel p (real or replicated)
	function automatic void window_enter(int t, logic [PIX_W-1:0] p, int r, int w);
		logic [PIX_W-1:0] leaving;
		int               k;
		if (t == 0) begin
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			// left edge replicates column 0
			sums_add_px(p, r + 1);
		end else if (t <= r) begin
			sums_add_px(p, 1);
		end else begin
			k = (t > 2 * r + 1) ? t - 2 * r - 1 : 0;
			leaving = (k == 0) ? {8'h00, first_rgb} : win_px[k % STORE_DEPTH];
			sums_drop_px(leaving);
			sums_add_px(p, 1);
		end
		if (t >= r)
			emit_blurred(r, w);
	endfunction

	function automatic void blur_pixel(logic [PIX_W-1:0] p);
		int r;
		int w;
		int c;
		int t;
		r = int'(radius_q);
		w = row_len();
		c = in_col;
		if (c >= w)
			c = 0;
		if (c == 0) begin
			first_rgb = p[COLOR_W-1:0];
			out_col = 0;
		end
		win_px[c % STORE_DEPTH] = p;
		window_enter(c, p, r, w);
		if (c == w - 1) begin
			// row end: right edge replicates the last pixel, flushing the rest
			for (t = w; t < w + r; t++)
				window_enter(t, p, r, w);
			in_col = 0;
			out_col = 0;
		end else begin
			in_col = c + 1;
		end
	endfunction

	// any write restarts the row
	function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
		case (idx)
			REG_RADIUS:    radius_q = val[RADIUS_W-1:0];
			REG_ROW_WIDTH: width_q  = val[ROW_W-1:0];
			default: ;
		endcase
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		in_col = 0;
		out_col = 0;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return 0;
		if (roll < 19)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0:       return '1;
			1:       return '0;
			2:       return {8'($urandom), 24'hFF_FFFF};
			default: return $urandom;
		endcase
	endfunction

	// present one pixel item after a random gap; predict on acceptance
	task automatic send_pixel(input logic [PIX_W-1:0] p, input logic typed,
		input blurred_t want);
		int gap;
		int mark;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		mark = blur_q.size();
		blur_pixel(p);
		if (typed) begin
			// keep predictor state, but hold the block to the value typed in the table
			while (blur_q.size() > mark)
				void'(blur_q.pop_back());
			blur_q.push_back(want);
		end
	endtask

	// block is idle once every owed item has arrived and the pipe has drained
	task automatic wait_idle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (blur_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_apply(idx, val);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------
	stim_row_t dir_rows [33] = '{
		// reset settings: radius 1, width 4096, row left open
		'{ROW_PIX, REG_RADIUS,    32'h0000_0000, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h1234_5678, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hFF00_FF00, 1'b0, '{32'h0, 1'b0}},
		// radius 0, one-pixel rows: every item comes back as it went in
		'{ROW_CFG, REG_RADIUS,    32'd0,         1'b0, '{32'h0, 1'b0}},
		'{ROW_CFG, REG_ROW_WIDTH, 32'd1,         1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
		'{ROW_PIX, REG_RADIUS,    32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
		'{ROW_PIX, REG_RADIUS,    32'hA5C3_7E01, 1'b1, '{32'hA5C3_7E01, 1'b1}},
		// widest window on a one-pixel row: 63 copies, mean is the pixel
		'{ROW_CFG, REG_RADIUS,    32'd31,        1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h80FF_00FF, 1'b1, '{32'h80FF_00FF, 1'b1}},
		'{ROW_PIX, REG_RADIUS,    32'h7F00_FF00, 1'b1, '{32'h7F00_FF00, 1'b1}},
		// ordinary row with edge replication on both sides
		'{ROW_CFG, REG_RADIUS,    32'd2,         1'b0, '{32'h0, 1'b0}},
		'{ROW_CFG, REG_ROW_WIDTH, 32'd5,         1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h0000_0000, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h00FF_FFFF, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hFF00_0000, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h5A5A_5A5A, 1'b0, '{32'h0, 1'b0}},
		// radius well past the row width: right side clamps to the last pixel
		'{ROW_CFG, REG_RADIUS,    32'd31,        1'b0, '{32'h0, 1'b0}},
		'{ROW_CFG, REG_ROW_WIDTH, 32'd3,         1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h0102_0304, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h0000_0000, 1'b0, '{32'h0, 1'b0}},
		// zero width acts as one pixel
		'{ROW_CFG, REG_ROW_WIDTH, 32'd0,         1'b0, '{32'h0, 1'b0}},
		'{ROW_CFG, REG_RADIUS,    32'd1,         1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h3CFF_FFFF, 1'b1, '{32'h3CFF_FFFF, 1'b1}},
		// oversized width clamps to the maximum; row stays open
		'{ROW_CFG, REG_ROW_WIDTH, ROW_REG_MAX,   1'b0, '{32'h0, 1'b0}},
		'{ROW_CFG, REG_RADIUS,    32'd2,         1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hC0FF_EE11, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h0080_8080, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'hFF7F_0180, 1'b0, '{32'h0, 1'b0}},
		'{ROW_PIX, REG_RADIUS,    32'h00FE_01FF, 1'b0, '{32'h0, 1'b0}}
	};

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		stim_row_t row;
		int        i;
		int        sent;
		int        w;
		int        count;
		int        which;
		int        val;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (i = 0; i < $size(dir_rows); i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.index, row.value);
			end else begin
				send_pixel(row.value, row.typed, row.want);
			end
		end

		// random phases: new settings, then mostly whole rows of random pixels
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			steady = ($urandom_range(0, 3) == 0);
			which = $urandom_range(0, 2);   // 0 radius only, 1 width only, 2 both
			if (which != 1) begin
				case ($urandom_range(0, 5))
					0:       val = 0;
					1:       val = MAX_RADIUS;
					default: val = $urandom_range(0, MAX_RADIUS);
				endcase
				write_reg(REG_RADIUS, val);
			end
			if (which != 0) begin
				case ($urandom_range(0, 11))
					0:       val = 0;
					1:       val = $urandom_range(MAX_WIDTH_DEF + 1, ROW_REG_MAX);
					2:       val = MAX_WIDTH_DEF;
					3:       val = $urandom_range(60, 70);   // wraps the window store
					default: val = $urandom_range(1, 12);
				endcase
				write_reg(REG_ROW_WIDTH, val);
			end
			w = row_len();
			if (w <= 70)
				count = w * ((w > 40) ? 1 : $urandom_range(1, 3));
			else
				count = $urandom_range(5, 40);   // long rows only ever partly sent
			// now and then leave a row unfinished; the next write cuts it off
			if (w > 1 && w <= 70 && $urandom_range(0, 4) == 0)
				count += $urandom_range(1, (w - 1 < 40) ? w - 1 : 40);
			repeat (count) send_pixel(rand_pixel(), 1'b0, '0);
			sent += count;
		end

		wait_idle();
		repeat (END_DRAIN) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls, quiet in steady phases
	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare every accepted result with the oldest owed item
	always @(posedge clk) begin
		blurred_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (blur_q.size() == 0) begin
				$error("unexpected item: pixel_out %h row_last %b", m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = blur_q.pop_front();
				if (m_axis_tdata !== want.pixel) begin
					$error("pixel_out: expected %h, got %h", want.pixel, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("row_last: expected %b, got %b", want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// hang detector: any handshake on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
